### rtl/core/best_fit_page_heap_allocator_macros.svh
// Assertion macros shared by the heap allocator RTL.
`ifndef BEST_FIT_PAGE_HEAP_ALLOCATOR_MACROS_SVH
`define BEST_FIT_PAGE_HEAP_ALLOCATOR_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define BFPHA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define BFPHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bfpha_pkg.sv
// Shared types, codes and defaults of the page heap allocator.
package bfpha_pkg;

    localparam int MAX_CHUNKS_DEF   = 32;
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int HEAP_PAGES_DEF   = 256;

    // Fixed field widths
    localparam int REQ_W  = 21;
    localparam int ADDR_W = 20;
    localparam int BRK_W  = 9;
    localparam int PG_W   = 23;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
    localparam logic [1:0] STAT_NO_SPACE = 2'd2;
    localparam logic [1:0] STAT_BAD_ADDR = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Command applied to the row of table cells
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SPLIT,
        S_MARK,
        S_APPEND,
        S_F_MARK,
        S_F_LEFT,
        S_F_LDEL,
        S_F_RIGHT,
        S_F_RDEL,
        S_F_TRIM,
        S_DONE
    } t_state;

endpackage

### rtl/core/bfpha_cell.sv
// One chunk table entry; loads, or shifts in from a neighbor on insert/remove.
module bfpha_cell #(
    parameter int IDX = 0,
    parameter int IW  = 5,
    parameter int AW  = 8,
    parameter int SW  = 9
) (
    input  logic                i_clk,
    input  bfpha_pkg::t_cell_op i_op,
    input  logic [IW-1:0]       i_pos,
    input  logic [AW-1:0]       i_ld_start,
    input  logic [SW-1:0]       i_ld_size,
    input  logic                i_ld_used,
    input  logic [AW-1:0]       i_l_start,
    input  logic [SW-1:0]       i_l_size,
    input  logic                i_l_used,
    input  logic [AW-1:0]       i_r_start,
    input  logic [SW-1:0]       i_r_size,
    input  logic                i_r_used,
    output logic [AW-1:0]       o_start,
    output logic [SW-1:0]       o_size,
    output logic                o_used
);
    import bfpha_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [AW-1:0] r_start, n_start;
    logic [SW-1:0] r_size, n_size;
    logic          r_used, n_used;

    // Entry update: load at pos, take left above pos on insert, take right at and above pos on remove
    always_comb begin
        n_start = r_start;
        n_size  = r_size;
        n_used  = r_used;
        case (i_op)
            CELL_LOAD: begin
                if (MY_IDX == i_pos) begin
                    n_start = i_ld_start;
                    n_size  = i_ld_size;
                    n_used  = i_ld_used;
                end
            end
            CELL_INS: begin
                if (MY_IDX == i_pos) begin
                    n_start = i_ld_start;
                    n_size  = i_ld_size;
                    n_used  = i_ld_used;
                end else if (MY_IDX > i_pos) begin
                    n_start = i_l_start;
                    n_size  = i_l_size;
                    n_used  = i_l_used;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= i_pos) begin
                    n_start = i_r_start;
                    n_size  = i_r_size;
                    n_used  = i_r_used;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_size  <= n_size;
        r_used  <= n_used;
    end

    assign o_start = r_start;
    assign o_size  = r_size;
    assign o_used  = r_used;

endmodule

### rtl/core/best_fit_page_heap_allocator.sv
// Best-fit page heap allocator: control sequencer over a row of table cells.
// Usage:
//  Input channel (i_in_valid / o_in_stall) carries operation, request_bytes
//  and payload_address; one beat is taken when valid is high and stall low.
//  Output channel (o_out_valid / i_out_stall) returns one beat per request:
//  result_address, status and break_pages after the request.
//  Config channel (i_cfg_valid / o_cfg_ready) writes heap_limit_pages; ready
//  is always high, writes are expected only while the block is idle.
//  Steps: allocate is accepted, scans the table entries in order until an
//  exact fit or the end, updates the table (split and mark, mark alone, or
//  append), then outputs. Free scans the same way up to its entry, marks it
//  free, merges it with free neighbours left and right and, if it is then the
//  last entry, drops it and lowers the break. Zero-size allocate and null
//  free skip the scan. One item is in work at a time, and a new one is taken
//  while a result waits in the output register.
//  Reset (synchronous, active low) empties the table, zeroes the break and
//  sets the limit to 256 pages. A stalled output holds its beat; the block
//  then finishes its current item and waits with o_in_stall high.
module best_fit_page_heap_allocator #(
    parameter int MAX_CHUNKS   = bfpha_pkg::MAX_CHUNKS_DEF,
    parameter int PAGE_BYTES   = bfpha_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = bfpha_pkg::HEADER_BYTES_DEF,
    parameter int HEAP_PAGES   = bfpha_pkg::HEAP_PAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic [bfpha_pkg::REQ_W-1:0]  i_request_bytes,
    input  logic [bfpha_pkg::ADDR_W-1:0] i_payload_address,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bfpha_pkg::ADDR_W-1:0] o_result_address,
    output logic [1:0]                   o_status,
    output logic [bfpha_pkg::BRK_W-1:0]  o_break_pages,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bfpha_pkg::BRK_W-1:0]  i_cfg_data
);
    import bfpha_pkg::*;

    localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int AW = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
    localparam int SW = $clog2(HEAP_PAGES + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [PG_W-1:0] ROUND_ADD = PG_W'(HEADER_BYTES + PAGE_BYTES - 1);
    localparam logic [PG_W-1:0] HEAP_PG   = PG_W'(HEAP_PAGES);
    localparam logic [CW-1:0]   MAX_CNT   = CW'(MAX_CHUNKS);

    // Control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [SW-1:0]   r_brk, n_brk;
    logic [BRK_W-1:0] r_limit;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_found, n_found;
    logic [IW-1:0]   r_best, n_best;
    logic [SW-1:0]   r_cur_size, n_cur_size;
    logic [AW-1:0]   r_cur_start, n_cur_start;
    logic            r_out_valid, n_out_valid;

    // Request and result payload
    logic            r_op;
    logic [PG_W-1:0] r_pages;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [1:0]        r_res_stat, n_res_stat;
    logic [ADDR_W-1:0] r_out_addr;
    logic [1:0]        r_out_stat;
    logic [BRK_W-1:0]  r_out_brk;

    // Cell row
    logic [AW-1:0] w_start [MAX_CHUNKS];
    logic [SW-1:0] w_size  [MAX_CHUNKS];
    logic          w_used  [MAX_CHUNKS];
    t_cell_op      c_op;
    logic [IW-1:0] c_pos;
    logic [AW-1:0] c_start;
    logic [SW-1:0] c_size;
    logic          c_used;

    logic [IW-1:0] rd_idx;
    logic [AW-1:0] rd_start;
    logic [SW-1:0] rd_size;
    logic          rd_used;
    logic [ADDR_W-1:0] rd_payload;
    logic [ADDR_W-1:0] best_payload;
    logic [ADDR_W-1:0] brk_payload;
    logic [PG_W-1:0] in_pages;
    logic [PG_W-1:0] lim;
    logic [SW-1:0]   rest;
    logic            in_acc;
    logic            out_free;

    genvar g;
    generate
        for (g = 0; g < MAX_CHUNKS; g++) begin : g_cell
            localparam int LI = (g > 0) ? g - 1 : 0;
            localparam int RI = (g < MAX_CHUNKS - 1) ? g + 1 : MAX_CHUNKS - 1;
            bfpha_cell #(.IDX(g), .IW(IW), .AW(AW), .SW(SW)) u_cell (
                .i_clk      (i_clk),
                .i_op       (c_op),
                .i_pos      (c_pos),
                .i_ld_start (c_start),
                .i_ld_size  (c_size),
                .i_ld_used  (c_used),
                .i_l_start  (w_start[LI]),
                .i_l_size   (w_size[LI]),
                .i_l_used   (w_used[LI]),
                .i_r_start  (w_start[RI]),
                .i_r_size   (w_size[RI]),
                .i_r_used   (w_used[RI]),
                .o_start    (w_start[g]),
                .o_size     (w_size[g]),
                .o_used     (w_used[g])
            );
        end
    endgenerate

    // Single read port into the row
    always_comb begin
        case (r_state)
            S_F_LEFT:  rd_idx = r_best - IW'(1);
            S_F_RIGHT: rd_idx = r_best + IW'(1);
            default:   rd_idx = r_idx[IW-1:0];
        endcase
    end
    assign rd_start = w_start[rd_idx];
    assign rd_size  = w_size[rd_idx];
    assign rd_used  = w_used[rd_idx];

    assign rd_payload   = ADDR_W'((32'(rd_start) << PAGE_SHIFT) + 32'(HEADER_BYTES));
    assign best_payload = ADDR_W'((32'(r_cur_start) << PAGE_SHIFT) + 32'(HEADER_BYTES));
    assign brk_payload  = ADDR_W'((32'(r_brk) << PAGE_SHIFT) + 32'(HEADER_BYTES));

    assign in_pages = (PG_W'(i_request_bytes) + ROUND_ADD) >> PAGE_SHIFT;
    assign lim      = (PG_W'(r_limit) < HEAP_PG) ? PG_W'(r_limit) : HEAP_PG;
    assign rest     = r_cur_size - SW'(r_pages);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer: next state, table commands, result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_brk       = r_brk;
        n_idx       = r_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_cur_size  = r_cur_size;
        n_cur_start = r_cur_start;
        n_res_addr  = r_res_addr;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid && i_out_stall;
        c_op    = CELL_HOLD;
        c_pos   = r_best;
        c_start = r_cur_start;
        c_size  = r_cur_size;
        c_used  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_res_addr = '0;
                    n_res_stat = STAT_OK;
                    if (i_operation == OP_ALLOC && i_request_bytes == '0) begin
                        n_res_stat = STAT_BAD_SIZE;
                        n_state    = S_DONE;
                    end else if (i_operation == OP_FREE && i_payload_address == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    if (r_op == OP_FREE) begin
                        n_res_stat = STAT_BAD_ADDR;
                        n_state    = S_DONE;
                    end else if (r_found) begin
                        n_state = (rest != '0 && r_count < MAX_CNT) ? S_SPLIT : S_MARK;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else if (r_op == OP_FREE) begin
                    n_idx = r_idx + CW'(1);
                    if (rd_used && rd_payload == r_addr) begin
                        n_best      = r_idx[IW-1:0];
                        n_cur_start = rd_start;
                        n_cur_size  = rd_size;
                        n_state     = S_F_MARK;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                    if (!rd_used && PG_W'(rd_size) >= r_pages) begin
                        if (PG_W'(rd_size) == r_pages) begin
                            n_best      = r_idx[IW-1:0];
                            n_cur_start = rd_start;
                            n_cur_size  = rd_size;
                            n_found     = 1'b1;
                            n_state     = S_MARK;
                        end else if (!r_found || rd_size < r_cur_size) begin
                            n_best      = r_idx[IW-1:0];
                            n_cur_start = rd_start;
                            n_cur_size  = rd_size;
                            n_found     = 1'b1;
                        end
                    end
                end
            end
            S_SPLIT: begin
                // open a free remainder entry right after the best fit
                c_op    = CELL_INS;
                c_pos   = r_best + IW'(1);
                c_start = r_cur_start + AW'(r_pages);
                c_size  = rest;
                c_used  = 1'b0;
                n_count    = r_count + CW'(1);
                n_cur_size = SW'(r_pages);
                n_state    = S_MARK;
            end
            S_MARK: begin
                c_op       = CELL_LOAD;
                c_used     = 1'b1;
                n_res_addr = best_payload;
                n_state    = S_DONE;
            end
            S_APPEND: begin
                if (r_count >= MAX_CNT || PG_W'(r_brk) > lim
                        || r_pages > lim - PG_W'(r_brk)) begin
                    n_res_stat = STAT_NO_SPACE;
                end else begin
                    c_op       = CELL_LOAD;
                    c_pos      = r_count[IW-1:0];
                    c_start    = AW'(r_brk);
                    c_size     = SW'(r_pages);
                    c_used     = 1'b1;
                    n_count    = r_count + CW'(1);
                    n_brk      = r_brk + SW'(r_pages);
                    n_res_addr = brk_payload;
                end
                n_state = S_DONE;
            end
            S_F_MARK: begin
                c_op    = CELL_LOAD;
                n_state = S_F_LEFT;
            end
            S_F_LEFT: begin
                n_state = S_F_RIGHT;
                if (r_best != '0 && !rd_used) begin
                    c_op        = CELL_LOAD;
                    c_pos       = rd_idx;
                    c_start     = rd_start;
                    c_size      = rd_size + r_cur_size;
                    n_cur_start = rd_start;
                    n_cur_size  = rd_size + r_cur_size;
                    n_state     = S_F_LDEL;
                end
            end
            S_F_LDEL: begin
                c_op    = CELL_DEL;
                n_count = r_count - CW'(1);
                n_best  = r_best - IW'(1);
                n_state = S_F_RIGHT;
            end
            S_F_RIGHT: begin
                n_state = S_F_TRIM;
                if (CW'(r_best) + CW'(1) < r_count && !rd_used) begin
                    c_op       = CELL_LOAD;
                    c_size     = r_cur_size + rd_size;
                    n_cur_size = r_cur_size + rd_size;
                    n_state    = S_F_RDEL;
                end
            end
            S_F_RDEL: begin
                c_op    = CELL_DEL;
                c_pos   = r_best + IW'(1);
                n_count = r_count - CW'(1);
                n_state = S_F_TRIM;
            end
            S_F_TRIM: begin
                if (CW'(r_best) + CW'(1) == r_count) begin
                    c_op    = CELL_DEL;
                    n_count = r_count - CW'(1);
                    n_brk   = SW'(r_cur_start);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_brk       <= '0;
            r_limit     <= BRK_W'(256);
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_best      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_brk       <= n_brk;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_best      <= n_best;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur_size  <= n_cur_size;
        r_cur_start <= n_cur_start;
        r_res_addr  <= n_res_addr;
        r_res_stat  <= n_res_stat;
        if (in_acc) begin
            r_op    <= i_operation;
            r_pages <= in_pages;
            r_addr  <= i_payload_address;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_addr <= r_res_addr;
            r_out_stat <= r_res_stat;
            r_out_brk  <= BRK_W'(r_brk);
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_stat;
    assign o_break_pages    = r_out_brk;

`include "best_fit_page_heap_allocator_macros.svh"

    `BFPHA_ASSERT_ALWAYS(a_count_max, r_count <= MAX_CNT, "chunk count above table size")
    `BFPHA_ASSERT_ALWAYS(a_brk_max, PG_W'(r_brk) <= HEAP_PG, "break above heap size")
    `BFPHA_ASSERT_ALWAYS(a_empty_brk, (r_count != '0) || (r_brk == '0), "empty table, break set")
    `BFPHA_ASSERT_NEXT(a_accept_leaves_idle, in_acc, r_state != S_IDLE, "accepted item lost")

endmodule

### tb/tb_best_fit_page_heap_allocator.sv
// Self-checking testbench of the best-fit page heap allocator with a scoreboard class.
module tb_best_fit_page_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import bfpha_pkg::*;

    localparam int NCHUNK = 32;
    localparam int PAGE = 4096;
    localparam int HDR = 24;
    localparam int HEAP = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    // Beat of the result channel
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        stat;
        logic [BRK_W-1:0]  brk;
    } t_heap_result;

    // Scoreboard: tracks the heap table and queues the predicted result beats
    class heap_scoreboard;
        int unsigned start_pg [NCHUNK];
        int unsigned size_pg [NCHUNK];
        bit          used [NCHUNK];
        int unsigned count;
        int unsigned brk;
        int unsigned limit_pg;
        t_heap_result pending[$];
        int errors;
        int n_checked;
        int n_stat [4];

        function void clear();
            count = 0;
            brk = 0;
            limit_pg = 256;
            pending.delete();
            errors = 0;
            n_checked = 0;
            foreach (n_stat[k]) n_stat[k] = 0;
        endfunction

        function int unsigned payload(int unsigned i);
            return (start_pg[i] * PAGE + HDR) & 20'hFFFFF;
        endfunction

        function void open_slot(int unsigned pos);
            for (int unsigned k = count; k > pos; k--) begin
                start_pg[k] = start_pg[k-1];
                size_pg[k] = size_pg[k-1];
                used[k] = used[k-1];
            end
            count++;
        endfunction

        function void close_slot(int unsigned pos);
            for (int unsigned k = pos; k + 1 < count; k++) begin
                start_pg[k] = start_pg[k+1];
                size_pg[k] = size_pg[k+1];
                used[k] = used[k+1];
            end
            count--;
        endfunction

        // Note an accepted request and predict its result beat
        function void note_request(logic op, logic [REQ_W-1:0] bytes, logic [ADDR_W-1:0] pa);
            t_heap_result r;
            int unsigned pages, best, lim, i, rest;
            bit found;
            r.addr = '0;
            r.stat = STAT_OK;
            if (op == OP_ALLOC) begin
                if (bytes == 0) begin
                    r.stat = STAT_BAD_SIZE;
                end else begin
                    pages = (int'(bytes) + HDR + PAGE - 1) / PAGE;
                    found = 0;
                    best = 0;
                    for (i = 0; i < count; i++) begin
                        if (used[i] || size_pg[i] < pages) continue;
                        if (size_pg[i] == pages) begin
                            best = i;
                            found = 1;
                            break;
                        end
                        if (!found || size_pg[i] < size_pg[best]) begin
                            best = i;
                            found = 1;
                        end
                    end
                    lim = (limit_pg < HEAP) ? limit_pg : HEAP;
                    if (found) begin
                        rest = size_pg[best] - pages;
                        if (rest != 0 && count < NCHUNK) begin
                            open_slot(best + 1);
                            start_pg[best+1] = start_pg[best] + pages;
                            size_pg[best+1] = rest;
                            used[best+1] = 0;
                            size_pg[best] = pages;
                        end
                        used[best] = 1;
                        r.addr = ADDR_W'(payload(best));
                    end else if (count >= NCHUNK || brk > lim || pages > lim - brk) begin
                        r.stat = STAT_NO_SPACE;
                    end else begin
                        start_pg[count] = brk;
                        size_pg[count] = pages;
                        used[count] = 1;
                        count++;
                        brk += pages;
                        r.addr = ADDR_W'(payload(count - 1));
                    end
                end
            end else if (pa != 0) begin
                found = 0;
                for (i = 0; i < count; i++) begin
                    if (used[i] && payload(i) == pa) begin
                        found = 1;
                        break;
                    end
                end
                if (!found) begin
                    r.stat = STAT_BAD_ADDR;
                end else begin
                    used[i] = 0;
                    if (i > 0 && !used[i-1]) begin
                        size_pg[i-1] += size_pg[i];
                        close_slot(i);
                        i--;
                    end
                    if (i + 1 < count && !used[i+1]) begin
                        size_pg[i] += size_pg[i+1];
                        close_slot(i + 1);
                    end
                    if (i + 1 == count) begin
                        brk = start_pg[i];
                        close_slot(i);
                    end
                end
            end
            r.brk = brk[BRK_W-1:0];
            pending.push_back(r);
        endfunction

        // Compare one result beat against the oldest prediction
        function void check_result(t_heap_result got);
            t_heap_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat addr=%0h status=%0d break=%0d",
                         $time, got.addr, got.stat, got.brk);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            n_checked++;
            n_stat[exp_r.stat]++;
            if (got.addr !== exp_r.addr) begin
                $display("%0t: result_address expected %0h actual %0h",
                         $time, exp_r.addr, got.addr);
                errors++;
            end
            if (got.stat !== exp_r.stat) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_r.stat, got.stat);
                errors++;
            end
            if (got.brk !== exp_r.brk) begin
                $display("%0t: break_pages expected %0d actual %0d", $time, exp_r.brk, got.brk);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic in_valid = 0;
    logic o_in_stall;
    logic req_op = 0;
    logic [REQ_W-1:0] req_bytes = '0;
    logic [ADDR_W-1:0] req_addr = '0;
    logic o_out_valid;
    logic out_stall = 0;
    logic [ADDR_W-1:0] o_result_address;
    logic [1:0] o_status;
    logic [BRK_W-1:0] o_break_pages;
    logic cfg_valid = 0;
    logic o_cfg_ready;
    logic [BRK_W-1:0] cfg_data = '0;

    heap_scoreboard sb;
    bit hold_off = 0;        // long receiver stall in progress
    bit hold_done = 0;       // long receiver stall already started
    bit stall_free = 0;      // receiver stretch without stalls
    int idle_cycles = 0;
    int unsigned live_addrs[$];   // payloads handed out and not yet freed
    int n_items = 0;

    always #5 i_clk = ~i_clk;

    best_fit_page_heap_allocator i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_operation(req_op),
        .i_request_bytes(req_bytes),
        .i_payload_address(req_addr),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_result_address(o_result_address),
        .o_status(o_status),
        .o_break_pages(o_break_pages),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(cfg_data)
    );

    // Receiver: checks result beats, stalls on its own pattern
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                sb.check_result('{o_result_address, o_status, o_break_pages});
                if (o_status == STAT_OK && o_result_address != 0)
                    live_addrs.push_back(32'(o_result_address));
            end
        end
        if (hold_off)
            out_stall <= 1'b1;
        else if (stall_free)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("best_fit_page_heap_allocator verification failed");
            $finish;
        end
    end

    // Offer one request beat and hold it until accepted
    task automatic send_request(logic op, logic [REQ_W-1:0] bytes, logic [ADDR_W-1:0] pa);
        in_valid <= 1'b1;
        req_op <= op;
        req_bytes <= bytes;
        req_addr <= pa;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(op, bytes, pa);
        n_items++;
    endtask

    task automatic idle_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Wait until every predicted result has come back, then let the block settle
    task automatic drain();
        idle_sender(1);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [BRK_W-1:0] pages);
        cfg_valid <= 1'b1;
        cfg_data <= pages;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        sb.limit_pg = pages;
    endtask

    // Random request: mostly frees of live payloads and allocations of mixed size
    task automatic random_request();
        int unsigned sel, idx;
        logic [REQ_W-1:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 40 && live_addrs.size() != 0) begin
            idx = $urandom_range(0, live_addrs.size() - 1);
            send_request(OP_FREE, '0, ADDR_W'(live_addrs[idx]));
            live_addrs.delete(idx);
        end else if (sel < 45) begin
            send_request(OP_FREE, '0, ADDR_W'($urandom_range(0, 20'hFFFFF)));
        end else if (sel < 48) begin
            send_request(OP_ALLOC, REQ_W'($urandom_range(0, 21'h1FFFFF)), ADDR_W'($urandom));
        end else begin
            case ($urandom_range(0, 3))
                0: b = REQ_W'($urandom_range(1, 4096 - HDR));
                1: b = REQ_W'($urandom_range(1, 4 * 4096));
                2: b = REQ_W'($urandom_range(1, 40 * 4096));
                default: b = REQ_W'($urandom_range(1, 1048576));
            endcase
            send_request(OP_ALLOC, b, ADDR_W'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero size, extremes, null and unknown frees, double free, merges
        send_request(OP_ALLOC, '0, 20'hFFFFF);
        send_request(OP_ALLOC, 21'd1, '0);
        send_request(OP_ALLOC, 21'd4072, '0);
        send_request(OP_ALLOC, 21'd4073, '0);
        send_request(OP_ALLOC, 21'd1048576, '0);
        send_request(OP_ALLOC, 21'h1FFFFF, '0);
        send_request(OP_FREE, 21'h1FFFFF, '0);
        send_request(OP_FREE, '0, 20'hFFFFF);
        send_request(OP_FREE, '0, ADDR_W'(4096 + HDR));
        send_request(OP_FREE, '0, ADDR_W'(4096 + HDR));
        send_request(OP_FREE, '0, 20'd24);
        send_request(OP_ALLOC, 21'd10000, '0);
        send_request(OP_ALLOC, 21'd100, '0);
        send_request(OP_FREE, '0, ADDR_W'(3 * 4096 + HDR));
        send_request(OP_FREE, '0, 20'd24);
        send_request(OP_FREE, '0, ADDR_W'(2 * 4096 + HDR));
        drain();

        // Tiny limit below the break, then zero limit
        write_limit(9'd1);
        send_request(OP_ALLOC, 21'd100, '0);
        send_request(OP_ALLOC, 21'd100, '0);
        drain();
        write_limit(9'd0);
        send_request(OP_ALLOC, 21'd100, '0);
        send_request(OP_FREE, '0, 20'd24);
        send_request(OP_ALLOC, 21'd100, '0);
        drain();
        write_limit(9'h1FF);
        // Fill the table: 33 one-page allocations, then free alternate ones and split
        for (int k = 0; k < 33; k++) send_request(OP_ALLOC, 21'd1, '0);
        drain();
        live_addrs.delete();
        for (int k = 0; k < 32; k += 2) send_request(OP_FREE, '0, ADDR_W'(k * 4096 + HDR));
        for (int k = 1; k < 32; k += 4) send_request(OP_FREE, '0, ADDR_W'(k * 4096 + HDR));
        send_request(OP_ALLOC, 21'd4096, '0);
        drain();
        for (int k = 0; k < 32; k++) send_request(OP_FREE, '0, ADDR_W'(k * 4096 + HDR));
        drain();

        // Random phases under several limits
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_limit(9'd256);
                1: write_limit(9'd12);
                2: write_limit(9'd300);
                3: write_limit(9'd64);
                default: write_limit(9'd256);
            endcase
            for (int n = 0; n < 210;) begin
                int burst;
                burst = $urandom_range(1, 20);
                stall_free = (ph == 4);
                if (ph == 2 && n >= 40 && !hold_done) begin
                    // Long receiver hold-off while requests keep coming
                    hold_done = 1;
                    fork
                        begin
                            hold_off = 1;
                            repeat (300) @(posedge i_clk);
                            hold_off = 0;
                        end
                    join_none
                end
                for (int b = 0; b < burst; b++) begin
                    random_request();
                    n++;
                end
                if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 60));
            end
            drain();
            // Free everything left so the next phase starts from a clean heap
            while (live_addrs.size() != 0)
                send_request(OP_FREE, '0, ADDR_W'(live_addrs.pop_front()));
            drain();
        end

        $display("Run covered %0d requests, %0d results: ok %0d, bad size %0d, no space %0d,",
                 n_items, sb.n_checked, sb.n_stat[0], sb.n_stat[1], sb.n_stat[2]);
        $display("unknown address %0d, across limits 0 to 511 including a long output stall.",
                 sb.n_stat[3]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("best_fit_page_heap_allocator verification clean");
        else
            $display("best_fit_page_heap_allocator verification failed");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/bfpha_pkg.sv
rtl/core/bfpha_cell.sv
rtl/core/best_fit_page_heap_allocator.sv
tb/tb_best_fit_page_heap_allocator.sv
